// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held low.
`define TCLFU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define TCLFU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/tclfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tclfu_pkg;

  // Command codes of the input transaction.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Fixed port widths.
  localparam int unsigned PORT_TAG_W = 63;
  localparam int unsigned PORT_IDX_W = 4;

endpackage

`default_nettype wire

// File: src/table_cache_lfu_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative tag directory with least-frequently-used replacement.
//
// Input channel: a transaction is taken on a rising edge with start high and
// busy low. busy is held low, so a transaction can be issued every cycle.
// in_command selects a lookup of in_table_tag or a clear of every way.
// Result channel: out_strobe is high for exactly one cycle per transaction,
// with out_hit, out_way_index and out_evicted_tag valid in that cycle. The
// receiver cannot stall, so results leave in issue order without back-pressure.
// Pipeline: the input register stage takes the transaction; the result register
// stage takes the outcome of the compare, the minimum tree and the state update,
// which all sit in that single stage.
// Throughput: one transaction per cycle; a transaction sees the directory
// as left by the one just before it.
// Reset (rst_n low, synchronous): all tags and use counts clear to zero
// (every way empty) and any transaction in flight is dropped.
// A lookup of tag zero leaves the directory untouched and returns all zeros.
module table_cache_lfu_replacement #(
  parameter int unsigned WAYS       = 16,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned TAG_BITS   = 63
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_command,
  input  wire logic [tclfu_pkg::PORT_TAG_W-1:0] in_table_tag,
  output logic                                  out_strobe,
  output logic                                  out_hit,
  output logic [tclfu_pkg::PORT_IDX_W-1:0]      out_way_index,
  output logic [tclfu_pkg::PORT_TAG_W-1:0]      out_evicted_tag
);

  localparam int unsigned WAY_W = $clog2(WAYS);
  // Index widened to at least the port width so the low bits can be taken.
  localparam int unsigned EXT_W =
    (WAY_W > tclfu_pkg::PORT_IDX_W) ? WAY_W : tclfu_pkg::PORT_IDX_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // Input register stage.
  logic                in_vld_r;
  logic                cmd_r;
  logic [TAG_BITS-1:0] tag_r;

  // Directory state.
  logic [WAYS-1:0][TAG_BITS-1:0]   tags_r, tags_nxt;
  logic [WAYS-1:0][COUNT_BITS-1:0] cnt_r,  cnt_nxt;

  // Result register stage.
  logic                              out_strobe_r;
  logic                              out_hit_r,  out_hit_nxt;
  logic [tclfu_pkg::PORT_IDX_W-1:0]  out_idx_r,  out_idx_nxt;
  logic [tclfu_pkg::PORT_TAG_W-1:0]  out_evict_r, out_evict_nxt;

  logic             hit;
  logic [WAY_W-1:0] hit_idx;
  logic [WAY_W-1:0] victim;
  logic             do_lookup;
  logic             do_clear;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic             saturate;
  logic [EXT_W-1:0] idx_ext;

  assign busy = 1'b0;

  tclfu_match #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_match (
    .tags    (tags_r),
    .key     (tag_r),
    .hit     (hit),
    .hit_idx (hit_idx)
  );

  tclfu_min_tree #(
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_min_tree (
    .counts (cnt_r),
    .victim (victim)
  );

  assign do_clear  = in_vld_r && (cmd_r == tclfu_pkg::CMD_CLEAR);
  // Tag zero marks empty ways, so it is never a real lookup.
  assign do_lookup = in_vld_r && (cmd_r == tclfu_pkg::CMD_LOOKUP) && (tag_r != '0);

  // Hit count never wraps at the counter width; reaching all ones halves every way.
  assign inc_cnt  = cnt_r[hit_idx] + CNT_ONE;
  assign saturate = (inc_cnt == CNT_MAX);

  always_comb begin
    tags_nxt      = tags_r;
    cnt_nxt       = cnt_r;
    out_hit_nxt   = 1'b0;
    idx_ext       = '0;
    out_evict_nxt = '0;
    if (do_clear) begin
      tags_nxt = '0;
      cnt_nxt  = '0;
    end else if (do_lookup && hit) begin
      for (int i = 0; i < WAYS; i++) begin
        if (WAY_W'(i) == hit_idx) begin
          cnt_nxt[i] = saturate ? (inc_cnt >> 1) : inc_cnt;
        end else if (saturate) begin
          cnt_nxt[i] = cnt_r[i] >> 1;
        end
      end
      out_hit_nxt = 1'b1;
      idx_ext     = EXT_W'(hit_idx);
    end else if (do_lookup) begin
      // Miss: replace the least-used way (empty ways hold count zero).
      tags_nxt[victim] = tag_r;
      cnt_nxt[victim]  = CNT_ONE;
      idx_ext          = EXT_W'(victim);
      out_evict_nxt    = tclfu_pkg::PORT_TAG_W'(tags_r[victim]);
    end
    out_idx_nxt = idx_ext[tclfu_pkg::PORT_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      tags_r       <= '0;
      cnt_r        <= '0;
    end else begin
      in_vld_r     <= start && !busy;
      out_strobe_r <= in_vld_r;
      tags_r       <= tags_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    cmd_r       <= in_command;
    tag_r       <= in_table_tag[TAG_BITS-1:0];
    out_hit_r   <= out_hit_nxt;
    out_idx_r   <= out_idx_nxt;
    out_evict_r <= out_evict_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_hit         = out_hit_r;
  assign out_way_index   = out_idx_r;
  assign out_evicted_tag = out_evict_r;

endmodule

`default_nettype wire

// File: src/tclfu_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Parallel tag compare over all ways; lowest matching way wins.
module tclfu_match #(
  parameter int unsigned WAYS     = 16,
  parameter int unsigned TAG_BITS = 63,
  localparam int unsigned WAY_W   = $clog2(WAYS)
) (
  input  wire logic [WAYS-1:0][TAG_BITS-1:0] tags,
  input  wire logic [TAG_BITS-1:0]           key,
  output logic                               hit,
  output logic [WAY_W-1:0]                   hit_idx
);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (tags[i] == key) begin
        hit     = 1'b1;
        hit_idx = WAY_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/tclfu_min_tree.sv
`timescale 1ns / 1ps
`default_nettype none

// Minimum tree over the use counts. Ties go to the left (lower) way, so the
// root gives the lowest-numbered way holding the smallest count.
module tclfu_min_tree #(
  parameter int unsigned WAYS       = 16,
  parameter int unsigned COUNT_BITS = 32,
  localparam int unsigned WAY_W     = $clog2(WAYS)
) (
  input  wire logic [WAYS-1:0][COUNT_BITS-1:0] counts,
  output logic [WAY_W-1:0]                     victim
);

  localparam int unsigned LEAVES = 1 << WAY_W;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  logic [COUNT_BITS-1:0] node_cnt [NODES];
  logic [WAY_W-1:0]      node_idx [NODES];

  // Padding leaves sit to the right at full count and never win a tie.
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < WAYS) begin : g_real
      assign node_cnt[LEAVES-1+g] = counts[g];
    end else begin : g_pad
      assign node_cnt[LEAVES-1+g] = '1;
    end
    assign node_idx[LEAVES-1+g] = WAY_W'(g);
  end

  for (genvar g = 0; g < LEAVES - 1; g++) begin : g_node
    logic take_right;
    assign take_right  = node_cnt[2*g+2] < node_cnt[2*g+1];
    assign node_cnt[g] = take_right ? node_cnt[2*g+2] : node_cnt[2*g+1];
    assign node_idx[g] = take_right ? node_idx[2*g+2] : node_idx[2*g+1];
  end

  assign victim = node_idx[0];

endmodule

`default_nettype wire

// File: src/tclfu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tclfu_checker #(
  parameter int unsigned TAG_BITS = 63
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             in_command,
  input wire logic [tclfu_pkg::PORT_TAG_W-1:0] in_table_tag,
  input wire logic                             out_strobe,
  input wire logic                             out_hit,
  input wire logic [tclfu_pkg::PORT_IDX_W-1:0] out_way_index,
  input wire logic [tclfu_pkg::PORT_TAG_W-1:0] out_evicted_tag
);

  logic acc;
  logic real_lookup;
  logic clear_acc;
  logic clear_res_zero;
  logic same_tag;
  logic repeat_res_hit;
  logic [tclfu_pkg::PORT_TAG_W-1:0] prev_tag_r;
  logic [tclfu_pkg::PORT_IDX_W-1:0] prev_way_r;

  assign acc         = start && !busy;
  assign real_lookup = acc && (in_command == tclfu_pkg::CMD_LOOKUP) &&
                       (in_table_tag[TAG_BITS-1:0] != '0);
  assign clear_acc   = acc && (in_command == tclfu_pkg::CMD_CLEAR);
  assign clear_res_zero = out_strobe && !out_hit && (out_way_index == '0) &&
                          (out_evicted_tag == '0);
  assign same_tag       = real_lookup && (in_table_tag == prev_tag_r);
  assign repeat_res_hit = out_strobe && out_hit && (out_way_index == prev_way_r);

  // Copies of the port values from the previous cycle.
  always_ff @(posedge clk) begin
    prev_tag_r <= in_table_tag;
    prev_way_r <= out_way_index;
  end

  // Every transaction yields a result.
  `TCLFU_ASSERT(a_result_follows, clk, rst_n, acc |-> ##2 out_strobe, "result missing")

  // No result without an earlier transaction.
  `TCLFU_ASSERT(a_no_spurious, clk, rst_n, out_strobe |-> $past(acc, 2), "spurious result")

  // A clear returns an all-zero result.
  `TCLFU_ASSERT(a_clear_zero, clk, rst_n, clear_acc |-> ##2 clear_res_zero, "clear not zero")

  // Looking up the same tag twice in a row hits the way that took it.
  `TCLFU_ASSERT(a_repeat_hits, clk, rst_n, (real_lookup ##1 same_tag) |-> ##2 repeat_res_hit, "repeat missed")

endmodule

bind table_cache_lfu_replacement tclfu_checker #(
  .TAG_BITS (TAG_BITS)
) u_tclfu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .in_table_tag    (in_table_tag),
  .out_strobe      (out_strobe),
  .out_hit         (out_hit),
  .out_way_index   (out_way_index),
  .out_evicted_tag (out_evicted_tag)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Self-checking bench for the LFU tag directory.
// Every transaction taken on the input channel is fed into a behavioural
// copy of the directory, which queues the result the block should produce.
// Results leave in issue order with no back-pressure, so each strobe is
// matched against the head of that queue, field by field.
module tb_top;

  localparam int unsigned NUM_WAYS   = 16;
  localparam logic [31:0] COUNT_FULL = 32'hffff_ffff;
  localparam int unsigned RAND_ITEMS = 1900;
  localparam int unsigned POOL_SIZE  = 24;
  // Even with every gap at its longest a run stays under this limit.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Extra cycles run after the last owed result has been checked.
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct {
    logic                             hit;
    logic [tclfu_pkg::PORT_IDX_W-1:0] way;
    logic [tclfu_pkg::PORT_TAG_W-1:0] evicted;
  } lookup_result_t;

  // Behavioural directory plus the queue of results still owed by the block.
  class lfu_scoreboard;
    logic [tclfu_pkg::PORT_TAG_W-1:0] dir_tags[NUM_WAYS];
    logic [31:0]                      use_cnt[NUM_WAYS];
    lookup_result_t                   owed_q[$];
    int                               errors;

    function void clear_dir();
      for (int i = 0; i < NUM_WAYS; i++) begin
        dir_tags[i] = '0;
        use_cnt[i]  = '0;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the directory by one accepted transaction; queue its result.
    function void note_input(logic cmd, logic [tclfu_pkg::PORT_TAG_W-1:0] tag);
      lookup_result_t r;
      int             found;
      int             victim;
      logic [31:0]    least;
      r.hit     = 1'b0;
      r.way     = '0;
      r.evicted = '0;
      found     = -1;
      victim    = 0;
      least     = COUNT_FULL;
      if (cmd == tclfu_pkg::CMD_CLEAR) begin
        clear_dir();
      end else if (tag != '0) begin
        // lowest-numbered match wins if a tag ever sits in two ways
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (found < 0 && dir_tags[i] == tag) found = i;
        end
        if (found >= 0) begin
          use_cnt[found] = use_cnt[found] + 32'd1;
          // saturation halves every count, the hit way included
          if (use_cnt[found] == COUNT_FULL) begin
            for (int i = 0; i < NUM_WAYS; i++) use_cnt[i] = use_cnt[i] >> 1;
          end
          r.hit = 1'b1;
          r.way = found[tclfu_pkg::PORT_IDX_W-1:0];
        end else begin
          // first way with the smallest count; way 0 if all saturated
          for (int i = 0; i < NUM_WAYS; i++) begin
            if (use_cnt[i] < least) begin
              least  = use_cnt[i];
              victim = i;
            end
          end
          r.evicted        = dir_tags[victim];
          r.way            = victim[tclfu_pkg::PORT_IDX_W-1:0];
          dir_tags[victim] = tag;
          use_cnt[victim]  = 32'd1;
        end
      end
      owed_q.push_back(r);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 20)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(logic hit, logic [tclfu_pkg::PORT_IDX_W-1:0] way,
                               logic [tclfu_pkg::PORT_TAG_W-1:0] evicted);
      lookup_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual hit %b way %h evicted %h",
                 $time, hit, way, evicted);
        return;
      end
      want = owed_q.pop_front();
      if (hit !== want.hit) report("hit", 64'(want.hit), 64'(hit));
      if (way !== want.way) report("way_index", 64'(want.way), 64'(way));
      if (evicted !== want.evicted) report("evicted_tag", 64'(want.evicted), 64'(evicted));
    endfunction
  endclass

  logic                             clk          = 1'b0;
  logic                             rst_n        = 1'b0;
  logic                             start        = 1'b0;
  logic                             in_command   = tclfu_pkg::CMD_LOOKUP;
  logic [tclfu_pkg::PORT_TAG_W-1:0] in_table_tag = '0;
  logic                             busy;
  logic                             out_strobe;
  logic                             out_hit;
  logic [tclfu_pkg::PORT_IDX_W-1:0] out_way_index;
  logic [tclfu_pkg::PORT_TAG_W-1:0] out_evicted_tag;

  lfu_scoreboard                    lfu_board;
  int unsigned                      cycle_count = 0;
  int unsigned                      burst_left  = 0;
  logic [tclfu_pkg::PORT_TAG_W-1:0] tag_pool[POOL_SIZE];

  table_cache_lfu_replacement dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_table_tag   (in_table_tag),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_way_index  (out_way_index),
    .out_evicted_tag(out_evicted_tag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Input monitor: a transaction counts on an edge with start high, busy low.
  // Values read here are the ones held before the edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) lfu_board.note_input(in_command, in_table_tag);
  end

  // Result monitor: the strobe lasts one cycle and cannot be held off.
  always @(posedge clk) begin
    if (rst_n && out_strobe) lfu_board.check_result(out_hit, out_way_index, out_evicted_tag);
  end

  function automatic logic [tclfu_pkg::PORT_TAG_W-1:0] rand_tag();
    return tclfu_pkg::PORT_TAG_W'({$urandom, $urandom});
  endfunction

  // Present one transaction and hold it until taken.
  task automatic issue(input logic cmd, input logic [tclfu_pkg::PORT_TAG_W-1:0] tag);
    start        <= 1'b1;
    in_command   <= cmd;
    in_table_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for the given gap; the payload wanders meanwhile, which must be ignored.
  task automatic pause(input int unsigned n);
    if (n > 0) begin
      start        <= 1'b0;
      in_command   <= 1'($urandom);
      in_table_tag <= rand_tag();
      repeat (n) @(posedge clk);
    end
  endtask

  // Mostly back to back or short gaps, a few long; bursts with no gap at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned r;
    int unsigned idx;
    logic [tclfu_pkg::PORT_TAG_W-1:0] tag;

    lfu_board = new;
    lfu_board.clear_dir();
    for (int i = 0; i < POOL_SIZE; i++) begin
      // a few small tags, the rest spread over the whole width
      tag_pool[i] = (i < 4) ? tclfu_pkg::PORT_TAG_W'(i + 1) : (rand_tag() | 63'd1);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: clear on an empty directory, the zero tag, extremes of
    // the tag, filling every way, a hit, eviction of the least used way and
    // a clear on a full directory.
    issue(tclfu_pkg::CMD_CLEAR, '0);
    issue(tclfu_pkg::CMD_LOOKUP, '0);
    issue(tclfu_pkg::CMD_LOOKUP, {tclfu_pkg::PORT_TAG_W{1'b1}});
    issue(tclfu_pkg::CMD_LOOKUP, {tclfu_pkg::PORT_TAG_W{1'b1}});
    pause(2);
    issue(tclfu_pkg::CMD_LOOKUP, 63'd1);
    issue(tclfu_pkg::CMD_LOOKUP, 63'h2aaa_aaaa_aaaa_aaaa);
    issue(tclfu_pkg::CMD_LOOKUP, 63'h5555_5555_5555_5555);
    for (int i = 3; i < NUM_WAYS; i++)
      issue(tclfu_pkg::CMD_LOOKUP, tclfu_pkg::PORT_TAG_W'(64'd1 << (i * 4)));
    // directory full: the miss must take way 1, the first way still at one use
    issue(tclfu_pkg::CMD_LOOKUP, 63'h4000_0000_0000_0000);
    issue(tclfu_pkg::CMD_LOOKUP, '0);
    issue(tclfu_pkg::CMD_CLEAR, {tclfu_pkg::PORT_TAG_W{1'b1}});
    issue(tclfu_pkg::CMD_LOOKUP, {tclfu_pkg::PORT_TAG_W{1'b1}});

    // Random part: most lookups hit a small pool with a hot subset, so hits,
    // misses and evictions all turn up; clears, zero tags and wide tags mixed in.
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      pause(pick_gap());
      r = $urandom_range(0, 999);
      if (r < 15) begin
        issue(tclfu_pkg::CMD_CLEAR, rand_tag());
      end else if (r < 45) begin
        issue(tclfu_pkg::CMD_LOOKUP, '0);
      end else if (r < 110) begin
        issue(tclfu_pkg::CMD_LOOKUP, rand_tag());
      end else begin
        idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5)
                                           : $urandom_range(0, POOL_SIZE - 1);
        // now and then a pool entry is replaced, so old tags age out
        if ($urandom_range(0, 99) < 2) tag_pool[idx] = rand_tag() | 63'd1;
        tag = tag_pool[idx];
        issue(tclfu_pkg::CMD_LOOKUP, tag);
      end
    end
    start <= 1'b0;

    while (lfu_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (lfu_board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
